// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the sprite overlay block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with an active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock aclk and reset aresetn.
`define ASSERT_ACLK(lbl, prop, msg) \
    `ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

// ----- rtl/core/rsao_pkg.sv -----
// Types and constants of the RGBA sprite alpha overlay unit.
package rsao_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_BLEND = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [10:0] col;
        logic [10:0] row;
        logic [7:0]  chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic [7:0]  chan3;
    } rsao_in_t;

    typedef struct packed {
        logic [7:0] out0;
        logic [7:0] out1;
        logic [7:0] out2;
        logic [7:0] out3;
        logic       covered;
    } rsao_out_t;

endpackage

// ----- rtl/core/rsao_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module rsao_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rgba_sprite_alpha_overlay_unit.sv -----
// Top level of the RGBA sprite alpha overlay unit: sprite store, placement and blend pipeline.
// A blend item's result passes the stage 1, stage 2 and output registers before m_valid rises.
// Throughput: one item per cycle when m_ready does not stall; each item uses the sprite RAM
// once (load: write port, blend: read port), and the three stages advance independently.
// Reset clears the pipeline valid flags and sets place_x = place_y = 0 and the sprite
// size to 128 x 128; the sprite RAM is not cleared and holds garbage until loaded.
module rgba_sprite_alpha_overlay_unit #(
    parameter int SPRITE_MAX_W = 128,
    parameter int SPRITE_MAX_H = 128,
    parameter int FRAME_MAX    = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rsao_pkg::rsao_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rsao_pkg::rsao_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsao_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsao_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import rsao_pkg::*;

    `include "assert_macros.svh"

    localparam int DEPTH  = SPRITE_MAX_W * SPRITE_MAX_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] MAX_W     = 32'(SPRITE_MAX_W);
    localparam logic [31:0] MAX_H     = 32'(SPRITE_MAX_H);
    localparam logic [31:0] FRAME_LIM = 32'(FRAME_MAX);

    // Configuration registers.
    logic [11:0] place_x_reg;
    logic [11:0] place_y_reg;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;

    // Front end: placement and address.
    logic              in_fire;
    logic [31:0]       w_eff;
    logic [31:0]       h_eff;
    logic signed [13:0] fx;
    logic signed [13:0] fy;
    logic              frame_ok;
    logic              in_sprite;
    logic              load_ok;
    logic [12:0]       sel_col;
    logic [12:0]       sel_row;
    logic [31:0]       addr_full;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;

    // Pipeline stages.
    logic            rdy1;
    logic            rdy2;
    logic            rdy_o;
    logic            v1_reg;
    logic            hit1_reg;
    logic [3:0][7:0] bg1_reg;
    logic            v2_reg;
    logic            cov2_reg;
    logic [3:0][7:0] bg2_reg;
    logic [3:0][15:0] p_reg;
    logic [3:0][15:0] p_next;
    logic [3:0][15:0] prod_bg;
    logic [3:0][15:0] prod_fg;
    logic [3:0][7:0] fg;
    logic [3:0][7:0] q;
    logic [7:0]      alpha;
    logic [7:0]      inv_alpha;
    logic            cov1;
    logic            vo_reg;
    rsao_out_t       out_reg;
    rsao_out_t       out_next;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            place_x_reg <= '0;
            place_y_reg <= '0;
            width_reg   <= 8'd128;
            height_reg  <= 8'd128;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PLACE_X: begin
                    place_x_reg <= cfg_data;
                end
                CFG_PLACE_Y: begin
                    place_y_reg <= cfg_data;
                end
                CFG_SPRITE_WIDTH: begin
                    width_reg <= cfg_data[7:0];
                end
                CFG_SPRITE_HEIGHT: begin
                    height_reg <= cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign rdy_o   = !vo_reg || m_ready;
    assign rdy2    = !v2_reg || rdy_o;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        w_eff = ({24'd0, width_reg} > MAX_W) ? MAX_W : {24'd0, width_reg};
        h_eff = ({24'd0, height_reg} > MAX_H) ? MAX_H : {24'd0, height_reg};
        fx = $signed({3'b000, s_data.col}) - $signed({{2{place_x_reg[11]}}, place_x_reg});
        fy = $signed({3'b000, s_data.row}) - $signed({{2{place_y_reg[11]}}, place_y_reg});
        frame_ok = ({21'd0, s_data.col} < FRAME_LIM) && ({21'd0, s_data.row} < FRAME_LIM);
        in_sprite = frame_ok && !fx[13] && !fy[13] &&
                    ({19'd0, fx[12:0]} < w_eff) && ({19'd0, fy[12:0]} < h_eff);
        load_ok = ({21'd0, s_data.col} < MAX_W) && ({21'd0, s_data.row} < MAX_H);
        if (s_data.mode == MODE_BLEND) begin
            sel_col = fx[12:0];
            sel_row = fy[12:0];
        end else begin
            sel_col = {2'b00, s_data.col};
            sel_row = {2'b00, s_data.row};
        end
        addr_full = {19'd0, sel_row} * MAX_W + {19'd0, sel_col};
    end

    assign ram_addr  = addr_full[ADDR_W-1:0];
    assign ram_we    = in_fire && (s_data.mode == MODE_LOAD) && load_ok;
    assign ram_wdata = {s_data.chan3, s_data.chan2, s_data.chan1, s_data.chan0};

    rsao_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_sprite_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (rdy1),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= in_fire && (s_data.mode == MODE_BLEND);
        end
        if (rdy1) begin
            hit1_reg   <= in_sprite;
            bg1_reg[0] <= s_data.chan0;
            bg1_reg[1] <= s_data.chan1;
            bg1_reg[2] <= s_data.chan2;
            bg1_reg[3] <= s_data.chan3;
        end
    end

    assign fg        = ram_rdata;
    assign alpha     = ram_rdata[31:24];
    assign inv_alpha = 8'd255 - alpha;
    assign cov1      = hit1_reg && (alpha != 8'd0);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            prod_bg[c] = 16'(bg1_reg[c]) * 16'(inv_alpha);
            prod_fg[c] = 16'(fg[c]) * 16'(alpha);
            p_next[c]  = prod_bg[c] + prod_fg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2) begin
            cov2_reg <= cov1;
            bg2_reg  <= bg1_reg;
            p_reg    <= p_next;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            q[c] = div255(p_reg[c]);
        end
        if (cov2_reg) begin
            out_next.out0 = q[0];
            out_next.out1 = q[1];
            out_next.out2 = q[2];
            out_next.out3 = q[3];
        end else begin
            out_next.out0 = bg2_reg[0];
            out_next.out1 = bg2_reg[1];
            out_next.out2 = bg2_reg[2];
            out_next.out3 = bg2_reg[3];
        end
        out_next.covered = cov2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (rdy_o) begin
            vo_reg <= v2_reg;
        end
        if (rdy_o) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vo_reg;
    assign m_data  = out_reg;

    `ASSERT_ACLK(a_load_no_result,
        (in_fire && (s_data.mode == MODE_LOAD) && rdy1) |=> !v1_reg,
        "A load item entered the blend pipeline.")

    `ASSERT_ACLK(a_miss_not_covered,
        (v1_reg && rdy2 && !hit1_reg) |=> !cov2_reg,
        "A pixel outside the sprite was marked covered.")

    `ASSERT_ACLK(a_stage2_holds,
        (v2_reg && !rdy_o) |=> (v2_reg && $stable(p_reg) && $stable(cov2_reg)),
        "Stage 2 changed while stalled.")

    `ASSERT_ACLK(a_div255_exact,
        (v2_reg && cov2_reg) |->
            ((24'(q[0]) * 24'd255 <= 24'(p_reg[0])) &&
             (24'(p_reg[0]) < 24'(q[0]) * 24'd255 + 24'd255)),
        "Division by 255 is not exact.")

endmodule

// ----- sim/tb_rgba_sprite_alpha_overlay_unit.sv -----
// Self-checking testbench for the RGBA sprite alpha overlay unit.
`timescale 1ns / 100ps

module tb_rgba_sprite_alpha_overlay_unit;
    import rsao_pkg::*;

    localparam int SPRITE_COLS = 128;
    localparam int SPRITE_ROWS = 128;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENTS = 18;
    localparam int SEGMENT_ITEMS = 50;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        rsao_in_t              px;
        bit                    fixed;
        rsao_out_t             want;
    } step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    rsao_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rsao_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [31:0] sprite_mem [SPRITE_COLS*SPRITE_ROWS];
    bit          sprite_loaded [SPRITE_COLS*SPRITE_ROWS];
    int          place_x = 0;
    int          place_y = 0;
    int          spr_w = 128;
    int          spr_h = 128;

    rsao_out_t   pixels_due [$];
    rsao_out_t   due_px;
    step_t       plan [$];
    int          fault_count = 0;
    int          stall_cycles = 0;
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;

    rgba_sprite_alpha_overlay_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int clip_w();
        return (spr_w > SPRITE_COLS) ? SPRITE_COLS : spr_w;
    endfunction

    function automatic int clip_h();
        return (spr_h > SPRITE_ROWS) ? SPRITE_ROWS : spr_h;
    endfunction

    function automatic void add_step(step_t s);
        plan.insert(plan.size(), s);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PLACE_X:       place_x = int'($signed(val));
            CFG_PLACE_Y:       place_y = int'($signed(val));
            CFG_SPRITE_WIDTH:  spr_w = int'(val[7:0]);
            CFG_SPRITE_HEIGHT: spr_h = int'(val[7:0]);
            default: ;
        endcase
    endfunction

    function automatic void store_pixel(rsao_in_t px);
        int idx;
        if (int'(px.col) < SPRITE_COLS && int'(px.row) < SPRITE_ROWS) begin
            idx = int'(px.row) * SPRITE_COLS + int'(px.col);
            sprite_mem[idx] = {px.chan3, px.chan2, px.chan1, px.chan0};
            sprite_loaded[idx] = 1'b1;
        end
    endfunction

    function automatic rsao_out_t overlay_pixel(rsao_in_t px);
        rsao_out_t   res;
        logic [31:0] fg;
        int          fx, fy, a, c;
        int          bg [4];
        int          mix [4];
        bg[0] = int'(px.chan0);
        bg[1] = int'(px.chan1);
        bg[2] = int'(px.chan2);
        bg[3] = int'(px.chan3);
        mix = bg;
        res.covered = 1'b0;
        fx = int'(px.col) - place_x;
        fy = int'(px.row) - place_y;
        if (fx >= 0 && fy >= 0 && fx < clip_w() && fy < clip_h()) begin
            fg = sprite_mem[fy * SPRITE_COLS + fx];
            a = int'(fg[31:24]);
            if (a != 0) begin
                res.covered = 1'b1;
                for (c = 0; c < 4; c++) begin
                    mix[c] = (bg[c] * (255 - a) + int'(fg[8*c +: 8]) * a) / 255;
                end
            end
        end
        res.out0 = 8'(mix[0]);
        res.out1 = 8'(mix[1]);
        res.out2 = 8'(mix[2]);
        res.out3 = 8'(mix[3]);
        return res;
    endfunction

    function automatic logic [7:0] rand_chan();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(19);
        if (r < 4) return 8'h00;
        if (r < 7) return 8'hFF;
        return 8'($urandom_range(254, 1));
    endfunction

    function automatic step_t pix_step(logic mode, int col, int row,
                                       logic [7:0] c0, logic [7:0] c1,
                                       logic [7:0] c2, logic [7:0] c3);
        step_t s;
        s.is_reg = 1'b0;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.px = {mode, 11'(col), 11'(row), c0, c1, c2, c3};
        s.fixed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t pass_step(int col, int row, logic [7:0] c0, logic [7:0] c1,
                                        logic [7:0] c2, logic [7:0] c3);
        step_t s;
        s = pix_step(MODE_BLEND, col, row, c0, c1, c2, c3);
        s.fixed = 1'b1;
        s.want = {c0, c1, c2, c3, 1'b0};
        return s;
    endfunction

    function automatic step_t fixed_step(step_t s, rsao_out_t want);
        step_t t;
        t = s;
        t.fixed = 1'b1;
        t.want = want;
        return t;
    endfunction

    function automatic step_t reg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        step_t s;
        s = pix_step(MODE_LOAD, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        s.is_reg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    task automatic push_pixel(input rsao_in_t px, input bit fixed, input rsao_out_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (px.mode == MODE_BLEND) begin
            pixels_due.insert(pixels_due.size(), fixed ? want : overlay_pixel(px));
        end else begin
            store_pixel(px);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic place_sprite(input int nx, input int ny, input int nw, input int nh);
        settle();
        write_reg(CFG_PLACE_X, 12'(nx));
        write_reg(CFG_PLACE_Y, 12'(ny));
        write_reg(CFG_SPRITE_WIDTH, {4'($urandom_range(15)), 8'(nw)});
        write_reg(CFG_SPRITE_HEIGHT, {4'($urandom_range(15)), 8'(nh)});
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(7, 4)), CFG_DATA_W'($urandom));
        end
    endtask

    task automatic run_segment(input int quota);
        int       done, w, h, fx, fy, col_i, row_i, r;
        rsao_in_t px;
        rsao_in_t ld;
        done = 0;
        w = clip_w();
        h = clip_h();
        while (done < quota) begin
            px.chan0 = rand_chan();
            px.chan1 = rand_chan();
            px.chan2 = rand_chan();
            px.chan3 = rand_chan();
            if ($urandom_range(99) < 28) begin
                px.mode = MODE_LOAD;
                px.chan3 = rand_alpha();
                r = $urandom_range(99);
                if (r < 80 && w > 0 && h > 0) begin
                    px.col = 11'($urandom_range(w - 1));
                    px.row = 11'($urandom_range(h - 1));
                end else if (r < 92) begin
                    px.col = 11'($urandom_range(SPRITE_COLS - 1));
                    px.row = 11'($urandom_range(SPRITE_ROWS - 1));
                end else if ($urandom_range(1) == 0) begin
                    px.col = 11'($urandom_range(2047, SPRITE_COLS));
                    px.row = 11'($urandom_range(2047));
                end else begin
                    px.col = 11'($urandom_range(2047));
                    px.row = 11'($urandom_range(2047, SPRITE_ROWS));
                end
                push_pixel(px, 1'b0, '0);
                if (int'(px.col) < SPRITE_COLS && int'(px.row) < SPRITE_ROWS) done++;
            end else begin
                px.mode = MODE_BLEND;
                col_i = -1;
                row_i = -1;
                if ($urandom_range(3) != 0 && w > 0 && h > 0) begin
                    col_i = place_x + int'($urandom_range(w + 3)) - 2;
                    row_i = place_y + int'($urandom_range(h + 3)) - 2;
                end
                if (col_i < 0 || col_i > 2047 || row_i < 0 || row_i > 2047) begin
                    col_i = $urandom_range(2047);
                    row_i = $urandom_range(2047);
                end
                px.col = 11'(col_i);
                px.row = 11'(row_i);
                fx = col_i - place_x;
                fy = row_i - place_y;
                if (fx >= 0 && fy >= 0 && fx < w && fy < h
                        && !sprite_loaded[fy * SPRITE_COLS + fx]) begin
                    ld = {MODE_LOAD, 11'(fx), 11'(fy), rand_chan(), rand_chan(),
                          rand_chan(), rand_alpha()};
                    push_pixel(ld, 1'b0, '0);
                    done++;
                end
                push_pixel(px, 1'b0, '0);
                done++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result: %h %h %h %h covered=%b",
                                 m_data.out0, m_data.out1, m_data.out2, m_data.out3,
                                 m_data.covered);
                    end
                end else begin
                    due_px = pixels_due.pop_front();
                    if (m_data.out0 !== due_px.out0 || m_data.out1 !== due_px.out1
                            || m_data.out2 !== due_px.out2 || m_data.out3 !== due_px.out3
                            || m_data.covered !== due_px.covered) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("mismatch: want %h %h %h %h cov=%b, got %h %h %h %h cov=%b",
                                     due_px.out0, due_px.out1, due_px.out2, due_px.out3,
                                     due_px.covered, m_data.out0, m_data.out1, m_data.out2,
                                     m_data.out3, m_data.covered);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int    seg, nx, ny, nw, nh, r;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 26;
        dst_idle_pct = 72;

        add_step(pass_step(2047, 2047, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_step(pass_step(0, 128, 8'h00, 8'h00, 8'h00, 8'h00));
        add_step(pass_step(128, 0, 8'hA5, 8'h5A, 8'h0F, 8'hF0));
        add_step(pix_step(MODE_LOAD, 0, 0, 8'h10, 8'h20, 8'h30, 8'hFF));
        add_step(fixed_step(pix_step(MODE_BLEND, 0, 0, 8'h99, 8'h88, 8'h77, 8'h66),
                            {8'h10, 8'h20, 8'h30, 8'hFF, 1'b1}));
        add_step(pix_step(MODE_LOAD, 1, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        add_step(pass_step(1, 0, 8'h01, 8'h02, 8'h03, 8'h04));
        add_step(pix_step(MODE_LOAD, 127, 127, 8'hFF, 8'hFF, 8'hFF, 8'h80));
        add_step(pix_step(MODE_BLEND, 127, 127, 8'h00, 8'h00, 8'h00, 8'h00));
        add_step(pix_step(MODE_LOAD, 0, 1, 8'h11, 8'h22, 8'h33, 8'h00));
        add_step(pix_step(MODE_LOAD, 128, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_step(pix_step(MODE_LOAD, 2047, 2047, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_step(pass_step(0, 1, 8'h05, 8'h06, 8'h07, 8'h08));
        add_step(pix_step(MODE_LOAD, 2, 0, 8'hFF, 8'h00, 8'hFF, 8'h01));
        add_step(pix_step(MODE_BLEND, 2, 0, 8'h00, 8'hFF, 8'h00, 8'hFF));
        add_step(reg_step(CFG_IDX_W'(4), 12'hFFF));
        add_step(reg_step(CFG_IDX_W'(7), 12'hFFF));
        add_step(pix_step(MODE_BLEND, 127, 127, 8'h40, 8'h80, 8'hC0, 8'hFF));
        add_step(reg_step(CFG_SPRITE_WIDTH, 12'h000));
        add_step(pass_step(0, 0, 8'h12, 8'h34, 8'h56, 8'h78));
        add_step(reg_step(CFG_SPRITE_WIDTH, 12'hFC8));
        add_step(reg_step(CFG_SPRITE_HEIGHT, 12'h0FF));
        add_step(pix_step(MODE_BLEND, 127, 127, 8'hFF, 8'h00, 8'h7F, 8'h80));
        add_step(reg_step(CFG_PLACE_X, 12'h800));
        add_step(reg_step(CFG_PLACE_Y, 12'h7FF));
        add_step(reg_step(CFG_SPRITE_WIDTH, 12'h080));
        add_step(reg_step(CFG_SPRITE_HEIGHT, 12'h001));
        add_step(pass_step(0, 2047, 8'h9A, 8'hBC, 8'hDE, 8'hF0));
        add_step(reg_step(CFG_PLACE_X, 12'hF81));
        add_step(reg_step(CFG_PLACE_Y, 12'hF81));
        add_step(reg_step(CFG_SPRITE_HEIGHT, 12'h080));
        add_step(pix_step(MODE_BLEND, 0, 0, 8'h55, 8'hAA, 8'h55, 8'hAA));
        add_step(reg_step(CFG_PLACE_X, 12'h7FF));
        add_step(reg_step(CFG_PLACE_Y, 12'h7FF));
        add_step(reg_step(CFG_SPRITE_WIDTH, 12'h001));
        add_step(reg_step(CFG_SPRITE_HEIGHT, 12'h001));
        add_step(fixed_step(pix_step(MODE_BLEND, 2047, 2047, 8'h00, 8'h00, 8'h00, 8'h00),
                            {8'h10, 8'h20, 8'h30, 8'hFF, 1'b1}));
        add_step(pass_step(2046, 2047, 8'hC3, 8'h3C, 8'hE7, 8'h18));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_pixel(plan[i].px, plan[i].fixed, plan[i].want);
            end
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < SEGMENTS / 3) begin
                src_idle_pct = 26;
                dst_idle_pct = 72;
            end else if (seg < 2 * SEGMENTS / 3) begin
                src_idle_pct = 72;
                dst_idle_pct = 26;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            case (seg)
                0: begin nx = 0;     ny = 0;     nw = 128; nh = 128; end
                1: begin nx = -2048; ny = -2048; nw = 255; nh = 255; end
                2: begin nx = 2047;  ny = 2047;  nw = 1;   nh = 1;   end
                3: begin nx = -5;    ny = -3;    nw = 0;   nh = 12;  end
                4: begin nx = 100;   ny = 7;     nw = 128; nh = 3;   end
                5: begin nx = -100;  ny = 2000;  nw = 16;  nh = 128; end
                default: begin
                    nx = ($urandom_range(4) == 0) ? int'($urandom_range(4095)) - 2048
                                                  : int'($urandom_range(200)) - 100;
                    ny = ($urandom_range(4) == 0) ? int'($urandom_range(4095)) - 2048
                                                  : int'($urandom_range(200)) - 100;
                    r = $urandom_range(9);
                    nw = (r == 0) ? 0 : (r == 1) ? $urandom_range(255, 128)
                                                 : $urandom_range(24, 1);
                    r = $urandom_range(9);
                    nh = (r == 0) ? 0 : (r == 1) ? $urandom_range(255, 128)
                                                 : $urandom_range(24, 1);
                end
            endcase
            place_sprite(nx, ny, nw, nh);
            run_segment(SEGMENT_ITEMS);
        end

        settle();
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- rgba_sprite_alpha_overlay_unit.f -----
+incdir+rtl/core
rtl/core/rsao_pkg.sv
rtl/core/rsao_ram.sv
rtl/core/rgba_sprite_alpha_overlay_unit.sv
sim/tb_rgba_sprite_alpha_overlay_unit.sv
